// ===== hdl/msvm_pkg.sv =====
// msvm_pkg: shared types and constants for the match score view max block
// depends on nothing; used by every module of the block
package msvm_pkg;

    // widths of the payload fields
    localparam int DistW  = 24;
    localparam int AmbW   = 16;
    localparam int ScoreW = 33;
    localparam int CountW = 11;
    localparam int CfgW   = 24;

    // default match count limit
    localparam int MAX_MATCHES_DEF = 1024;

    // register indexes of the configuration port
    localparam logic CFG_MAX_DISTANCE  = 1'b0;
    localparam logic CFG_MAX_AMBIGUITY = 1'b1;

    // register reset values
    localparam logic [DistW-1:0] MaxDistanceRst  = 24'd65536;
    localparam logic [AmbW-1:0]  MaxAmbiguityRst = 16'd26214;

    // reciprocal 2^32/d: any d up to CapDistance clamps to RecipCap,
    // any larger d gives a quotient that fits in RecipW bits
    localparam int                RecipW      = 23;
    localparam logic [RecipW-1:0] RecipCap    = 23'd6553600;
    localparam logic [DistW-1:0]  CapDistance = 24'd655;
    localparam int                RemW        = DistW + 1;
    // upper part of the dividend 2^32 above the quotient bits
    localparam logic [RemW-1:0]   DivInit     = 25'd512;

    // saturation of the view sum, 1024 * 100.0 in Q.16
    localparam logic [ScoreW-1:0] SumCap = 33'd6710886400;

    // depth of the queue between front and back
    localparam int QDepth = 2;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic             has_match;
        logic             good;
        logic [DistW-1:0] distance;
        logic             view_end;
        logic             model_end;
    } msvm_item_t;

endpackage

// ===== hdl/msvm_front.sv =====
// msvm_front: configuration registers and classification of incoming matches
// depends on msvm_pkg; feeds msvm_queue
module msvm_front
    import msvm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             has_match,
    input  logic [DistW-1:0] distance,
    input  logic [AmbW-1:0]  ambiguity,
    input  logic             view_end,
    input  logic             model_end,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CfgW-1:0]  cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output msvm_item_t       q_item
);

    logic [DistW-1:0] max_distance_reg, max_distance_next;
    logic [AmbW-1:0]  max_ambiguity_reg, max_ambiguity_next;
    logic             view_stopped_reg, view_stopped_next;
    logic             scored;
    logic             over;

    // configuration writes
    always_comb
    begin
        max_distance_next  = max_distance_reg;
        max_ambiguity_next = max_ambiguity_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_DISTANCE:  max_distance_next  = cfg_data;
                CFG_MAX_AMBIGUITY: max_ambiguity_next = cfg_data[AmbW-1:0];
                default:           max_distance_next  = max_distance_reg;
            endcase
        end
    end

    // classify: a match is looked at unless the view stopped or it is ambiguous
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign scored   = has_match && !view_stopped_reg && (ambiguity < max_ambiguity_reg);
    assign over     = distance > max_distance_reg;

    always_comb
    begin
        q_item.has_match = has_match;
        q_item.good      = scored && !over;
        q_item.distance  = distance;
        q_item.view_end  = view_end;
        q_item.model_end = view_end && model_end;
    end

    // view stop flag, cleared at each view end
    always_comb
    begin
        view_stopped_next = view_stopped_reg;
        if (q_push)
        begin
            if (view_end)
                view_stopped_next = 1'b0;
            else if (scored && over)
                view_stopped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg  <= MaxDistanceRst;
            max_ambiguity_reg <= MaxAmbiguityRst;
            view_stopped_reg  <= 1'b0;
        end
        else
        begin
            max_distance_reg  <= max_distance_next;
            max_ambiguity_reg <= max_ambiguity_next;
            view_stopped_reg  <= view_stopped_next;
        end
    end

endmodule

// ===== hdl/msvm_queue.sv =====
// msvm_queue: short fifo of classified items between front and back
// depends on msvm_pkg
module msvm_queue
    import msvm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  msvm_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output msvm_item_t head
);

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QDepth);

    msvm_item_t      mem_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full      = cnt_reg == FullCnt;
    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hdl/msvm_back.sv =====
// msvm_back: serial reciprocal, view accumulation and result register
// depends on msvm_pkg; drains msvm_queue
module msvm_back
    import msvm_pkg::*;
#(
    parameter int MAX_MATCHES = MAX_MATCHES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  msvm_item_t        q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ScoreW-1:0] view_score,
    output logic [CountW-1:0] good_count,
    output logic [CountW-1:0] total_count,
    output logic [ScoreW-1:0] model_score,
    output logic              last_of_model
);

    localparam int CountCapInt = (MAX_MATCHES > 2047) ? 2047 : MAX_MATCHES;
    localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);
    localparam int StepW = $clog2(RecipW);
    localparam logic [StepW-1:0] LastStep = StepW'(RecipW - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_ADD, ST_EMIT} state_t;

    state_t            state_reg;
    msvm_item_t        ent_reg;
    logic [RemW-1:0]   rem_reg;
    logic [RecipW-1:0] quo_reg;
    logic [StepW-1:0]  step_reg;
    logic [ScoreW-1:0] sum_reg;
    logic [ScoreW-1:0] best_reg;
    logic [CountW-1:0] good_reg;
    logic [CountW-1:0] all_reg;
    logic              out_valid_reg;
    logic [ScoreW-1:0] view_score_reg;
    logic [CountW-1:0] good_count_reg;
    logic [CountW-1:0] total_count_reg;
    logic [ScoreW-1:0] model_score_reg;
    logic              last_reg;

    logic [RemW-1:0]   rem_shift;
    logic              rem_ge;
    logic [ScoreW:0]   sum_wide;
    logic [ScoreW-1:0] sum_sat;
    logic [ScoreW-1:0] best_new;
    logic              out_free;

    // one restoring division step
    assign rem_shift = {rem_reg[RemW-2:0], 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, ent_reg.distance};

    // saturating accumulate of the reciprocal
    assign sum_wide = {1'b0, sum_reg} + (ScoreW+1)'(quo_reg);
    assign sum_sat  = (sum_wide > {1'b0, SumCap}) ? SumCap : sum_wide[ScoreW-1:0];

    // running maximum including the closing view
    assign best_new = (sum_reg > best_reg) ? sum_reg : best_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;

    assign out_valid     = out_valid_reg;
    assign view_score    = view_score_reg;
    assign good_count    = good_count_reg;
    assign total_count   = total_count_reg;
    assign model_score   = model_score_reg;
    assign last_of_model = last_reg;

    // sequencer with accumulators and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ent_reg         <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            step_reg        <= '0;
            sum_reg         <= '0;
            best_reg        <= '0;
            good_reg        <= '0;
            all_reg         <= '0;
            out_valid_reg   <= 1'b0;
            view_score_reg  <= '0;
            good_count_reg  <= '0;
            total_count_reg <= '0;
            model_score_reg <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            // result taken downstream, unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        ent_reg  <= q_head;
                        rem_reg  <= DivInit;
                        step_reg <= LastStep;
                        if (q_head.good && (q_head.distance > CapDistance))
                        begin
                            quo_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            quo_reg   <= RecipCap;
                            state_reg <= ST_ADD;
                        end
                    end
                end

                ST_DIV:
                begin
                    rem_reg  <= rem_ge ? rem_shift - {1'b0, ent_reg.distance} : rem_shift;
                    quo_reg  <= {quo_reg[RecipW-2:0], rem_ge};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                        state_reg <= ST_ADD;
                end

                ST_ADD:
                begin
                    if (ent_reg.has_match && (all_reg < CountCap))
                        all_reg <= all_reg + 1'b1;
                    if (ent_reg.good)
                    begin
                        sum_reg <= sum_sat;
                        if (good_reg < CountCap)
                            good_reg <= good_reg + 1'b1;
                    end
                    state_reg <= ent_reg.view_end ? ST_EMIT : ST_IDLE;
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        view_score_reg  <= sum_reg;
                        good_count_reg  <= good_reg;
                        total_count_reg <= all_reg;
                        model_score_reg <= best_new;
                        last_reg        <= ent_reg.model_end;
                        best_reg        <= ent_reg.model_end ? '0 : best_new;
                        sum_reg         <= '0;
                        good_reg        <= '0;
                        all_reg         <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/match_score_view_max_top.sv =====
// a view end item with a good match above the clamp distance offers its result after
// acceptance via the queue, the back load, 23 divide steps, an add and an emit;
// the back takes a new item only from idle, so such a match holds it through the
// 23-step serial reciprocal divider; the emit waits while a stalled result is held
// reset: rst_n clears all view and model state, limits return to their defaults
// match_score_view_max_top: front, queue and back; depends on msvm_pkg
module match_score_view_max_top
    import msvm_pkg::*;
#(
    parameter int MAX_MATCHES = MAX_MATCHES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              has_match,
    input  logic [DistW-1:0]  distance,
    input  logic [AmbW-1:0]   ambiguity,
    input  logic              view_end,
    input  logic              model_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ScoreW-1:0] view_score,
    output logic [CountW-1:0] good_count,
    output logic [CountW-1:0] total_count,
    output logic [ScoreW-1:0] model_score,
    output logic              last_of_model,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CfgW-1:0]   cfg_data
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    msvm_item_t q_item;
    msvm_item_t q_head;

    // classification front
    msvm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .has_match (has_match),
        .distance  (distance),
        .ambiguity (ambiguity),
        .view_end  (view_end),
        .model_end (model_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    // decoupling queue
    msvm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // scoring back end
    msvm_back #(
        .MAX_MATCHES (MAX_MATCHES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .view_score    (view_score),
        .good_count    (good_count),
        .total_count   (total_count),
        .model_score   (model_score),
        .last_of_model (last_of_model)
    );

endmodule

// ===== hdl/msvm_checker.sv =====
// msvm_checker: port level checks of the result channel over time
// depends on msvm_pkg; bound to match_score_view_max_top
module msvm_checker
    import msvm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [ScoreW-1:0] view_score,
    input logic [CountW-1:0] good_count,
    input logic [CountW-1:0] total_count,
    input logic [ScoreW-1:0] model_score
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its score
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(view_score) && $stable(model_score))
        else $error("stalled result changed");

    // good matches are a subset of all matches
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> good_count <= total_count)
        else $error("good count above total count");

    // model maximum covers the view just closed
    a_model_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> model_score >= view_score)
        else $error("model score below view score");

endmodule

bind match_score_view_max_top msvm_checker u_msvm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .view_score  (view_score),
    .good_count  (good_count),
    .total_count (total_count),
    .model_score (model_score)
);
